// ===== rtl/core/rgb_to_hsv_converter_top_defines.svh =====
// Assertion macros shared by the RGB to HSV converter modules.
// Expects signals named clk and rst_n in the including scope.
`ifndef RGB_TO_HSV_CONVERTER_TOP_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_TOP_DEFINES_SVH

// Check that a condition holds at every clock edge out of reset.
`define RHC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in the cycle after a trigger follows from it.
`define RHC_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rhc_pkg.sv =====
// Package of the RGB to HSV converter: widths, the work item type and
// the divider step function. No dependencies.
`timescale 1ns / 1ps

package rhc_pkg;

    localparam int CHAN_W     = 20;
    localparam int VAL_W      = CHAN_W - 1;
    localparam int FRAC_W     = 16;
    localparam int HUE_DIV_W  = VAL_W + 3;
    localparam int SAT_W      = FRAC_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [HUE_DIV_W-1:0] hue_rem;
        logic [HUE_DIV_W-1:0] hue_div;
        logic [FRAC_W-1:0]    hue_q;
        logic [VAL_W-1:0]     sat_rem;
        logic [VAL_W-1:0]     sat_div;
        logic [SAT_W-1:0]     sat_q;
        logic [VAL_W-1:0]     value;
        logic [CHAN_W-1:0]    alpha;
    } work_t;

    // One restoring division step for both quotients.
    function automatic work_t div_step(work_t w);
        work_t                o;
        logic [HUE_DIV_W:0]   ht;
        logic [VAL_W:0]       st;
        o  = w;
        ht = {w.hue_rem, 1'b0};
        st = {w.sat_rem, 1'b0};
        if (ht >= {1'b0, w.hue_div})
        begin
            ht      = ht - {1'b0, w.hue_div};
            o.hue_q = {w.hue_q[FRAC_W-2:0], 1'b1};
        end
        else
        begin
            o.hue_q = {w.hue_q[FRAC_W-2:0], 1'b0};
        end
        if (st >= {1'b0, w.sat_div})
        begin
            st      = st - {1'b0, w.sat_div};
            o.sat_q = {w.sat_q[SAT_W-2:0], 1'b1};
        end
        else
        begin
            o.sat_q = {w.sat_q[SAT_W-2:0], 1'b0};
        end
        o.hue_rem = ht[HUE_DIV_W-1:0];
        o.sat_rem = st[VAL_W-1:0];
        return o;
    endfunction

endpackage

// ===== rtl/core/rhc_front.sv =====
// Front part: accept a pixel, clamp, classify the sector and set up
// both divisions. Depends on rhc_pkg.
`timescale 1ns / 1ps

module rhc_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [rhc_pkg::CHAN_W-1:0] red,
    input  logic [rhc_pkg::CHAN_W-1:0] green,
    input  logic [rhc_pkg::CHAN_W-1:0] blue,
    input  logic [rhc_pkg::CHAN_W-1:0] alpha,
    output logic                       q_push,
    input  logic                       q_full,
    output rhc_pkg::work_t             q_data
);

    localparam int VW = rhc_pkg::VAL_W;
    localparam int HW = rhc_pkg::HUE_DIV_W;

    logic           valid_reg, valid_next;
    rhc_pkg::work_t item_reg;
    rhc_pkg::work_t item_next;
    logic [VW-1:0]  r, g, b, hi, lo, d;
    logic [HW:0]    n_wide;
    logic [HW-1:0]  n, six_d;
    logic           take;

    assign full   = valid_reg && q_full;
    assign take   = push && !full;
    assign q_push = valid_reg && !q_full;
    assign q_data = item_reg;

    always_comb
    begin
        r  = red[rhc_pkg::CHAN_W-1]   ? '0 : red[VW-1:0];
        g  = green[rhc_pkg::CHAN_W-1] ? '0 : green[VW-1:0];
        b  = blue[rhc_pkg::CHAN_W-1]  ? '0 : blue[VW-1:0];
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        d     = hi - lo;
        six_d = ({3'b0, d} << 2) + ({3'b0, d} << 1);
        // sector offset by the minimum channel, red first
        if (r == lo)
            n_wide = ({4'b0, d} << 1) + {4'b0, d} + {4'b0, b} - {4'b0, g};
        else if (g == lo)
            n_wide = ({4'b0, d} << 2) + {4'b0, d} + {4'b0, r} - {4'b0, b};
        else
            n_wide = {4'b0, d} + {4'b0, g} - {4'b0, r};
        n = n_wide[HW-1:0];
        if (n >= six_d)
            n = n - six_d;

        item_next.hue_rem = n;
        item_next.hue_div = (d == '0) ? HW'(1) : six_d;
        item_next.hue_q   = '0;
        // saturation of one happens only with d equal to max
        item_next.sat_q   = {{(rhc_pkg::SAT_W-1){1'b0}}, (d == hi) && (d != '0)};
        item_next.sat_rem = (d == hi) ? '0 : d;
        item_next.sat_div = (hi == '0) ? VW'(1) : hi;
        item_next.value   = hi;
        item_next.alpha   = alpha;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (q_push)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
    end

endmodule

// ===== rtl/core/rhc_queue.sv =====
// Short queue between front and back parts.
// Depends on rhc_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "rgb_to_hsv_converter_top_defines.svh"

module rhc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           q_full,
    input  rhc_pkg::work_t wr_data,
    input  logic           pop,
    output logic           q_empty,
    output rhc_pkg::work_t rd_data
);

    localparam int PW = rhc_pkg::QPTR_W;
    localparam int CW = rhc_pkg::QCNT_W;

    rhc_pkg::work_t slot_reg [rhc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign q_full  = (cnt_reg == CW'(rhc_pkg::QUEUE_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_push = push && !q_full;
    assign do_pop  = pop && !q_empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(rhc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(rhc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    `RHC_ASSERT(a_cnt_bound, cnt_reg <= CW'(rhc_pkg::QUEUE_DEPTH), "queue count past depth")
    `RHC_ASSERT(a_no_push_full, !(push && q_full), "front pushed into full queue")
    `RHC_ASSERT_NEXT(a_cnt_up, do_push && !do_pop, cnt_reg == $past(cnt_reg) + 1'b1, "count missed a push")

endmodule

// ===== rtl/core/rhc_back.sv =====
// Back part: pipelined restoring dividers, one quotient bit per stage.
// Depends on rhc_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "rgb_to_hsv_converter_top_defines.svh"

module rhc_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  rhc_pkg::work_t             q_data,
    output logic                       q_pop,
    input  logic                       pop,
    output logic                       empty,
    output logic [rhc_pkg::FRAC_W-1:0] hue,
    output logic [rhc_pkg::SAT_W-1:0]  saturation,
    output logic [rhc_pkg::VAL_W-1:0]  value,
    output logic [rhc_pkg::CHAN_W-1:0] alpha_out
);

    localparam int NS = rhc_pkg::FRAC_W;

    rhc_pkg::work_t stage_reg [NS];
    logic [NS-1:0]  vld_reg, vld_next;
    logic           advance;

    // The whole pipe moves unless the finished result is stalled.
    assign advance = !vld_reg[NS-1] || pop;
    assign q_pop   = advance && !q_empty;
    assign vld_next = {vld_reg[NS-2:0], !q_empty};

    assign empty      = !vld_reg[NS-1];
    assign hue        = stage_reg[NS-1].hue_q;
    assign saturation = stage_reg[NS-1].sat_q;
    assign value      = stage_reg[NS-1].value;
    assign alpha_out  = stage_reg[NS-1].alpha;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg[0] <= rhc_pkg::div_step(q_data);
            for (int k = 1; k < NS; k++)
                stage_reg[k] <= rhc_pkg::div_step(stage_reg[k-1]);
        end
    end

    `RHC_ASSERT(a_hue_rem, !vld_reg[NS-1] || (stage_reg[NS-1].hue_rem < stage_reg[NS-1].hue_div), "hue remainder not below divisor")
    `RHC_ASSERT_NEXT(a_hold, vld_reg[NS-1] && !pop, vld_reg[NS-1], "stalled result dropped")

endmodule

// ===== rtl/core/rgb_to_hsv_converter_top.sv =====
// Top level of the RGB to HSV converter.
// Depends on rhc_pkg, rhc_front, rhc_queue and rhc_back.
`timescale 1ns / 1ps
//
//  channel | handshake          | fields
//  --------+--------------------+-----------------------------------
//  input   | push / full        | red, green, blue, alpha (20b signed)
//  result  | empty / pop        | hue 16b, saturation 17b, value 19b,
//          |                    | alpha_out 20b
//
//  One pixel a cycle is taken and one result a cycle delivered while no
//  stalled result holds the divider pipe. From the accepting edge, an item
//  passes the front register, a queue slot and then the 16 divider stages
//  (one quotient bit each, sized by the 16 fraction bits of the results) in
//  that order, and the result shows once it reaches the last stage.
//  Reset clears the valid flags, queue pointers and queue count; no payload clears.
//  A stalled result holds the divider pipe; the queue then fills and
//  the front register raises full once both are occupied.

module rgb_to_hsv_converter_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [rhc_pkg::CHAN_W-1:0] red,
    input  logic [rhc_pkg::CHAN_W-1:0] green,
    input  logic [rhc_pkg::CHAN_W-1:0] blue,
    input  logic [rhc_pkg::CHAN_W-1:0] alpha,
    input  logic                       pop,
    output logic                       empty,
    output logic [rhc_pkg::FRAC_W-1:0] hue,
    output logic [rhc_pkg::SAT_W-1:0]  saturation,
    output logic [rhc_pkg::VAL_W-1:0]  value,
    output logic [rhc_pkg::CHAN_W-1:0] alpha_out
);

    // front to queue transfer
    logic           fq_push;
    logic           fq_full;
    rhc_pkg::work_t fq_data;
    // queue to back transfer
    logic           qb_pop;
    logic           qb_empty;
    rhc_pkg::work_t qb_data;

    // Clamp, classify the sector and set up the dividers.
    rhc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .red    (red),
        .green  (green),
        .blue   (blue),
        .alpha  (alpha),
        .q_push (fq_push),
        .q_full (fq_full),
        .q_data (fq_data)
    );

    // Decouple front and back so each can stall on its own.
    rhc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fq_push),
        .q_full  (fq_full),
        .wr_data (fq_data),
        .pop     (qb_pop),
        .q_empty (qb_empty),
        .rd_data (qb_data)
    );

    // Run both divisions and present the result.
    rhc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (qb_empty),
        .q_data     (qb_data),
        .q_pop      (qb_pop),
        .pop        (pop),
        .empty      (empty),
        .hue        (hue),
        .saturation (saturation),
        .value      (value),
        .alpha_out  (alpha_out)
    );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the RGB to HSV converter top level.
// Depends on rhc_pkg and rgb_to_hsv_converter_top.
`timescale 1ns / 1ps

module tb;

    localparam int CW = rhc_pkg::CHAN_W;
    localparam int FW = rhc_pkg::FRAC_W;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [CW-1:0] r;
        logic [CW-1:0] g;
        logic [CW-1:0] b;
        logic [CW-1:0] a;
    } pixel_t;

    typedef struct packed {
        logic [FW-1:0]          h;
        logic [rhc_pkg::SAT_W-1:0] s;
        logic [rhc_pkg::VAL_W-1:0] v;
        logic [CW-1:0]          a;
    } hsv_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic [CW-1:0] red = '0, green = '0, blue = '0, alpha = '0;
    logic [FW-1:0] hue;
    logic [rhc_pkg::SAT_W-1:0] saturation;
    logic [rhc_pkg::VAL_W-1:0] value;
    logic [CW-1:0] alpha_out;

    pixel_t pixel_q[$];
    hsv_t   hsv_expected_q[$];
    int     mismatches = 0;
    int     cycles = 0;
    bit     hold_off = 1'b0;   // receiver long stall request
    bit     sender_wait = 1'b0; // sender pause until drained
    int     push_gap = 0;
    int     pop_gap = 0;

    rgb_to_hsv_converter_top u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .red(red), .green(green), .blue(blue), .alpha(alpha),
        .pop(pop), .empty(empty), .hue(hue), .saturation(saturation),
        .value(value), .alpha_out(alpha_out)
    );

    always #5 clk = ~clk;

    // Pick a gap length: mostly zero or short, occasionally long.
    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Clamp negative channels to zero.
    function automatic logic [CW-1:0] clamp_chan(logic [CW-1:0] c);
        return c[CW-1] ? '0 : c;
    endfunction

    // Compute the expected HSV result of one pixel.
    function automatic hsv_t convert_pixel(pixel_t p);
        hsv_t o;
        longint unsigned r, g, b, hi, lo, d, n;
        r = clamp_chan(p.r);
        g = clamp_chan(p.g);
        b = clamp_chan(p.b);
        hi = r; lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        o = '0;
        if (hi != lo)
        begin
            d = hi - lo;
            if (r == lo) n = 3 * d + b - g;
            else if (g == lo) n = 5 * d + r - b;
            else n = d + g - r;
            if (n >= 6 * d) n = n - 6 * d;
            o.h = FW'((n << FW) / (6 * d));
            o.s = rhc_pkg::SAT_W'((d << FW) / hi);
        end
        o.v = hi[rhc_pkg::VAL_W-1:0];
        o.a = p.a;
        return o;
    endfunction

    function automatic logic [CW-1:0] rand_chan();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return CW'($urandom_range(0, 15));
        if (k == 1) return {1'b1, (CW-1)'($urandom)};
        if (k == 2) return 20'h7FFFF - CW'($urandom_range(0, 15));
        return CW'($urandom);
    endfunction

    task automatic add_pixel(input logic [CW-1:0] r, g, b, a);
        pixel_t p;
        p = '{r: r, g: g, b: b, a: a};
        pixel_q.push_back(p);
    endtask

    // Driver: advance the pending queue on each transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                hsv_expected_q.push_back(convert_pixel(pixel_q.pop_front()));
            end
            if (push && full)
            begin
                // hold the item until it transfers
            end
            else if (push_gap > 0)
            begin
                push <= 1'b0;
                push_gap <= push_gap - 1;
            end
            else if (sender_wait || pixel_q.size() == 0)
            begin
                push <= 1'b0;
            end
            else
            begin
                // next item to offer: head after a possible pop above
                if (pixel_q.size() > 0 && (push_gap == 0))
                begin
                    if ((push && !full) && pick_gap() != 0)
                    begin
                        push <= 1'b0;
                        push_gap <= pick_gap();
                    end
                    else
                    begin
                        push  <= 1'b1;
                        red   <= pixel_q[0].r;
                        green <= pixel_q[0].g;
                        blue  <= pixel_q[0].b;
                        alpha <= pixel_q[0].a;
                    end
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        hsv_t e;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (hsv_expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result h=%0d s=%0d v=%0d a=%0h",
                                 hue, saturation, value, alpha_out);
                end
                else
                begin
                    e = hsv_expected_q.pop_front();
                    if (hue !== e.h || saturation !== e.s || value !== e.v
                        || alpha_out !== e.a)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp h=%0d s=%0d v=%0d a=%0h got h=%0d s=%0d v=%0d a=%0h",
                                     e.h, e.s, e.v, e.a, hue, saturation, value, alpha_out);
                    end
                end
            end
            if (hold_off)
            begin
                pop <= 1'b0;
            end
            else if (pop_gap > 0)
            begin
                pop <= 1'b0;
                pop_gap <= pop_gap - 1;
            end
            else if (pop && pick_gap() != 0)
            begin
                pop <= 1'b0;
                pop_gap <= pick_gap();
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Cycle counter; end the run on timeout.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Long receiver stall, counted here while the sender keeps offering.
    initial
    begin
        wait (rst_n);
        repeat (300) @(posedge clk);
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        int i;
        logic [CW-1:0] x;
        repeat (10) @(posedge clk);
        rst_n = 1'b1;

        // Directed: extremes, equal channels, each minimum channel, wrap case.
        add_pixel(20'h00000, 20'h00000, 20'h00000, 20'h00000);
        add_pixel(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'hFFFFF);
        add_pixel(20'h80000, 20'h80000, 20'h80000, 20'h80000);
        add_pixel(20'h7FFFF, 20'h00000, 20'h00000, 20'h7FFFF);
        add_pixel(20'h00000, 20'h7FFFF, 20'h00000, 20'h12345);
        add_pixel(20'h00000, 20'h00000, 20'h7FFFF, 20'h54321);
        add_pixel(20'h80000, 20'h7FFFF, 20'h00001, 20'hABCDE);
        add_pixel(20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h00001);
        add_pixel(20'h7FFFF, 20'h7FFFF, 20'h80000, 20'hFFFFE);
        add_pixel(20'h01000, 20'h00000, 20'h00001, 20'h0);     // hue near full turn
        add_pixel(20'h00001, 20'h00000, 20'h00000, 20'h1);
        add_pixel(20'h00002, 20'h00001, 20'h00001, 20'h2);
        add_pixel(20'h00001, 20'h00002, 20'h00001, 20'h3);
        add_pixel(20'h00001, 20'h00001, 20'h00002, 20'h4);
        add_pixel(20'h00005, 20'h00005, 20'h00003, 20'h5);
        add_pixel(20'hFFFFF, 20'h00010, 20'h00010, 20'h6);
        add_pixel(20'h00003, 20'h00007, 20'h00005, 20'h7);

        for (i = 0; i < 250; i++)
            add_pixel(rand_chan(), rand_chan(), rand_chan(), CW'($urandom));

        // Pause the sender until everything has come back.
        wait (pixel_q.size() == 0);
        sender_wait = 1'b1;
        wait (hsv_expected_q.size() == 0 && !push);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sender_wait = 1'b0;

        for (i = 0; i < 290; i++)
        begin
            x = rand_chan();
            if ($urandom_range(0, 5) == 0)
                add_pixel(x, x, x, CW'($urandom));
            else
                add_pixel(rand_chan(), rand_chan(), rand_chan(), CW'($urandom));
        end

        wait (pixel_q.size() == 0 && !push);
        wait (hsv_expected_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
